// ----- rtl/drdd_pkg.sv -----
// Constants and shared types for the depth run/delta decoder.
`timescale 1ns / 1ps

package drdd_pkg;

   localparam int WORD_BITS = 32;                 // compressed word width
   localparam int NIB_BITS  = 4;                  // one code nibble
   localparam int DATA_BITS = 3;                  // data bits per nibble
   localparam int NIBBLES   = WORD_BITS / NIB_BITS;
   localparam int NIB_IDX_BITS = $clog2(NIBBLES);
   localparam int GROUP_BITS   = 4;
   localparam int CFG_BITS     = 24;              // frame_pixels register width

   localparam logic [GROUP_BITS-1:0] GROUP_MAX  = 4'd15;  // saturation point
   localparam logic [GROUP_BITS-1:0] GROUP_LAST = 4'd10;  // last group that fits 32 bits
   localparam logic [DATA_BITS-1:0]  TOP_GROUP_MAX_DATA = 3'd3; // bits 30..31 only

   localparam logic [CFG_BITS-1:0] FRAME_PIXELS_RESET = 24'd307200;

   // Decoder phase: which kind of value the next completed code is.
   typedef enum logic [1:0] {
      PH_ZERO_RUN  = 2'd0,
      PH_NZ_RUN    = 2'd1,
      PH_DELTA     = 2'd2
   } phase_type;

endpackage

// ----- rtl/depth_run_delta_decoder_top.sv -----
// Depth run/delta decoder: nibble-serial decode of compressed depth words into runs.
`timescale 1ns / 1ps

// Decodes a run/delta compressed depth image. Each accepted 32-bit word is
// worked through one nibble per clock by a single datapath (accumulate, one
// clamp compare/subtract against the remaining pixel count, one delta adder),
// most significant nibble first. Each word is accepted, worked through its
// eight nibbles, and its final result handed off; a word that ends a frame
// stops early at the closing nibble and drops the rest as padding. The
// nibble loop pauses while the output register is still full and a new
// result has to go out. req_tready is high only between words. Each nonzero
// or flagged zero-run count gives one result (pixel 0, count); each delta
// gives one pixel with repeat 1; status results (count 0) carry frame end or
// error flags. rsp_tlast marks the last result produced by one input word.
// Writing frame_pixels on the csr port (taken only between words) also
// rearms the decoder for a new frame.
module depth_run_delta_decoder_top #(
   parameter int PIXEL_BITS = 16,
   parameter int COUNT_BITS = 24,
   localparam int RSP_DATA_BITS = ((PIXEL_BITS + COUNT_BITS + 7) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration: frame_pixels
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [drdd_pkg::CFG_BITS-1:0]   csr_wdata,
   // compressed input
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [drdd_pkg::WORD_BITS-1:0]  req_tdata,   // [31:0] code_word
   // decoded runs
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [RSP_DATA_BITS-1:0]        rsp_tdata,   // pixel_value, repeat_count, zero pad
   output logic [1:0]                      rsp_tuser,   // [0] frame_done, [1] format_error
   output logic                            rsp_tlast
);

   import drdd_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FLUSH
   } seq_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pix;
      logic [COUNT_BITS-1:0] cnt;
      logic                  done;
      logic                  err;
   } result_type;

   // sequencer
   seq_type                  state_ff, state_in;
   logic [NIB_IDX_BITS-1:0]  nib_idx_ff, nib_idx_in;
   logic [WORD_BITS-1:0]     word_ff, word_in;

   // decoder state
   logic [CFG_BITS-1:0]      frame_pixels_ff, frame_pixels_in;
   logic [WORD_BITS-1:0]     acc_ff, acc_in;
   logic [GROUP_BITS-1:0]    group_ff, group_in;
   phase_type                phase_ff, phase_in;
   logic [COUNT_BITS-1:0]    run_left_ff, run_left_in;
   logic [COUNT_BITS-1:0]    pix_left_ff, pix_left_in;
   logic [PIXEL_BITS-1:0]    prev_ff, prev_in;

   // newest result, held until we know whether it ends the word
   result_type               held_ff, held_in;
   logic                     held_valid_ff, held_valid_in;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   result_type               rsp_res_ff, rsp_res_in;
   logic                     rsp_last_ff, rsp_last_in;

   // nibble datapath
   logic [NIB_BITS-1:0]      nib;
   logic [DATA_BITS-1:0]     dat;
   logic [5:0]               shamt;
   logic [WORD_BITS-1:0]     acc_sum;
   logic                     over;
   logic                     clamp_hit;
   logic [COUNT_BITS-1:0]    cnt_clamped;
   logic [WORD_BITS-1:0]     delta;
   logic [COUNT_BITS-1:0]    run_dec;
   logic                     frame_end;
   logic                     step_res_valid;
   result_type               step_res;

   logic                     out_free;
   logic                     advance;

   // ---------------------------------------------------------------
   // One nibble of decode
   // ---------------------------------------------------------------
   always_comb begin
      nib   = word_ff[WORD_BITS-1 -: NIB_BITS];
      dat   = nib[DATA_BITS-1:0];
      shamt = 6'({1'b0, group_ff, 1'b0}) + 6'(group_ff);       // 3 * group
      acc_sum = acc_ff;
      if (group_ff <= GROUP_LAST) begin
         acc_sum = acc_ff | (WORD_BITS'(dat) << shamt);
      end
      over = (group_ff > GROUP_LAST) ||
             ((group_ff == GROUP_LAST) && (dat > TOP_GROUP_MAX_DATA));

      // shared clamp: count against pixels left in the frame
      clamp_hit   = acc_sum > WORD_BITS'(pix_left_ff);
      cnt_clamped = clamp_hit ? pix_left_ff : acc_sum[COUNT_BITS-1:0];

      // zigzag decode
      delta   = (acc_sum >> 1) ^ (WORD_BITS'(0) - WORD_BITS'(acc_sum[0]));
      run_dec = run_left_ff - COUNT_BITS'(1);

      acc_in      = acc_ff;
      group_in    = group_ff;
      phase_in    = phase_ff;
      run_left_in = run_left_ff;
      pix_left_in = pix_left_ff;
      prev_in     = prev_ff;
      frame_end   = 1'b0;
      step_res_valid = 1'b0;
      step_res    = '0;

      if (nib[NIB_BITS-1]) begin
         // continuation: more groups of this value follow
         acc_in   = acc_sum;
         group_in = (group_ff < GROUP_MAX) ? group_ff + GROUP_BITS'(1) : GROUP_MAX;
      end else begin
         acc_in   = '0;
         group_in = '0;
         case (phase_ff)
            PH_DELTA: begin
               prev_in     = prev_ff + delta[PIXEL_BITS-1:0];
               run_left_in = run_dec;
               if (run_dec == '0) begin
                  if (pix_left_ff == '0) begin
                     frame_end = 1'b1;
                  end else begin
                     phase_in = PH_ZERO_RUN;
                  end
               end
               step_res_valid = 1'b1;
               step_res.pix   = prev_in;
               step_res.cnt   = COUNT_BITS'(1);
               step_res.done  = frame_end;
               step_res.err   = over;
            end
            PH_NZ_RUN: begin
               pix_left_in = pix_left_ff - cnt_clamped;
               step_res.err = over | clamp_hit;
               if (cnt_clamped != '0) begin
                  phase_in       = PH_DELTA;
                  run_left_in    = cnt_clamped;
                  step_res_valid = over | clamp_hit;
               end else if (pix_left_in == '0) begin
                  frame_end      = 1'b1;
                  step_res.done  = 1'b1;
                  step_res_valid = 1'b1;
               end else begin
                  phase_in       = PH_ZERO_RUN;
                  step_res_valid = over | clamp_hit;
               end
            end
            default: begin
               // zero-run count (the unused phase code acts the same)
               pix_left_in    = pix_left_ff - cnt_clamped;
               phase_in       = PH_NZ_RUN;
               step_res.cnt   = cnt_clamped;
               step_res.err   = over | clamp_hit;
               step_res_valid = (cnt_clamped != '0) | over | clamp_hit;
            end
         endcase
      end

      if (frame_end) begin
         // rearm for the next frame
         acc_in      = '0;
         group_in    = '0;
         phase_in    = PH_ZERO_RUN;
         run_left_in = '0;
         pix_left_in = COUNT_BITS'(frame_pixels_ff);
         prev_in     = '0;
      end
   end

   // ---------------------------------------------------------------
   // Sequencer and result hand-off
   // ---------------------------------------------------------------
   assign out_free = !rsp_valid_ff || rsp_tready;
   // stall a nibble only when it makes a result and both holding spots are full
   assign advance  = (state_ff == ST_RUN) &&
                     !(step_res_valid && held_valid_ff && !out_free);

   always_comb begin
      state_in        = state_ff;
      nib_idx_in      = nib_idx_ff;
      word_in         = word_ff;
      frame_pixels_in = frame_pixels_ff;
      held_in         = held_ff;
      held_valid_in   = held_valid_ff;
      rsp_res_in      = rsp_res_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               word_in    = req_tdata;
               nib_idx_in = '0;
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            if (advance) begin
               word_in    = word_ff << NIB_BITS;
               nib_idx_in = nib_idx_ff + NIB_IDX_BITS'(1);
               if (step_res_valid) begin
                  if (held_valid_ff) begin
                     rsp_res_in   = held_ff;
                     rsp_last_in  = 1'b0;
                     rsp_valid_in = 1'b1;
                  end
                  held_in       = step_res;
                  held_valid_in = 1'b1;
               end
               if (frame_end || (nib_idx_ff == NIB_IDX_BITS'(NIBBLES - 1))) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!held_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_res_in    = held_ff;
               rsp_last_in   = 1'b1;
               rsp_valid_in  = 1'b1;
               held_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_valid && (state_ff == ST_IDLE)) begin
         frame_pixels_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         nib_idx_ff      <= '0;
         frame_pixels_ff <= FRAME_PIXELS_RESET;
         acc_ff          <= '0;
         group_ff        <= '0;
         phase_ff        <= PH_ZERO_RUN;
         run_left_ff     <= '0;
         pix_left_ff     <= COUNT_BITS'(FRAME_PIXELS_RESET);
         prev_ff         <= '0;
         held_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         nib_idx_ff      <= nib_idx_in;
         frame_pixels_ff <= frame_pixels_in;
         held_valid_ff   <= held_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_valid && (state_ff == ST_IDLE)) begin
            // a frame_pixels write rearms the decoder
            acc_ff      <= '0;
            group_ff    <= '0;
            phase_ff    <= PH_ZERO_RUN;
            run_left_ff <= '0;
            pix_left_ff <= COUNT_BITS'(csr_wdata);
            prev_ff     <= '0;
         end else if (advance) begin
            acc_ff      <= acc_in;
            group_ff    <= group_in;
            phase_ff    <= phase_in;
            run_left_ff <= run_left_in;
            pix_left_ff <= pix_left_in;
            prev_ff     <= prev_in;
         end
      end
      word_ff     <= word_in;
      held_ff     <= held_in;
      rsp_res_ff  <= rsp_res_in;
      rsp_last_ff <= rsp_last_in;
   end

   // ---------------------------------------------------------------
   // Ports
   // ---------------------------------------------------------------
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_res_ff.err, rsp_res_ff.done};

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[PIXEL_BITS-1:0]          = rsp_res_ff.pix;
      rsp_tdata[PIXEL_BITS +: COUNT_BITS] = rsp_res_ff.cnt;
   end

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the depth run/delta decoder top level.
`timescale 1ns / 1ps

module tb_top;
   import drdd_pkg::*;

   localparam int          RSP_BITS    = 40;      // 16 pixel + 24 count, byte aligned
   localparam int          SETTLE      = 24;      // settle time after the last expected run
   localparam int          RANDOM_WORDS = 260;
   localparam int unsigned CYCLE_LIMIT = 600000;

   // One decoded run as seen on the result stream.
   typedef struct packed {
      logic signed [15:0] pixel;
      logic [23:0]        count;
      logic               done;
      logic               err;
      logic               last;
   } run_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CFG_BITS-1:0]   csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [WORD_BITS-1:0]  req_tdata = '0;    // [31:0] code_word
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]   rsp_tdata;         // [15:0] pixel_value, [39:16] repeat_count
   logic [1:0]            rsp_tuser;         // [0] frame_done, [1] format_error
   logic                  rsp_tlast;

   depth_run_delta_decoder_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Bookkeeping
   // ------------------------------------------------------------------
   logic [31:0]  pending_words[$];   // words waiting for the driver
   run_type      expected_runs[$];   // predicted runs, oldest first
   logic [3:0]   code_nibs[$];       // encoder scratch, first nibble first
   int unsigned  words_queued   = 0;
   int unsigned  words_accepted = 0;
   int unsigned  fail_count     = 0;
   int unsigned  cycle_count    = 0;
   int unsigned  send_gap       = 0;
   int unsigned  stall_left     = 0;
   logic         quiet;

   // One stretch in four of the cycle count runs with no idling on either side.
   assign quiet = ((cycle_count / 500) % 4) == 3;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // ------------------------------------------------------------------
   // Decoder shadow state
   // ------------------------------------------------------------------
   logic [23:0]  frame_cfg;
   logic [31:0]  acc;
   logic [3:0]   grp_idx;
   phase_type    phase;
   logic [23:0]  run_left;
   logic [23:0]  pix_left;
   logic [15:0]  prev_pix;

   function automatic void rearm_decoder();
      acc      = '0;
      grp_idx  = '0;
      phase    = PH_ZERO_RUN;
      run_left = '0;
      pix_left = frame_cfg;
      prev_pix = '0;
   endfunction

   // Walk one word nibble by nibble and queue the runs it produces.
   function automatic void decode_word(input logic [31:0] word);
      run_type     outs[$];
      run_type     tail;
      logic [3:0]  nib;
      logic [2:0]  d;
      logic [3:0]  g;
      logic [31:0] v;
      logic [31:0] delta;
      logic        over;
      logic        err;
      logic        done;
      logic        stop;
      stop = 1'b0;
      for (int i = 0; i < NIBBLES; i++) begin
         if (!stop) begin
            nib  = word[31 - 4 * i -: 4];
            d    = nib[2:0];
            g    = grp_idx;
            done = 1'b0;
            // groups past bit 31 are simply dropped
            if (g <= GROUP_LAST) acc = acc | 32'(64'(d) << (3 * g));
            if (nib[3]) begin
               grp_idx = (g < GROUP_MAX) ? g + 4'd1 : GROUP_MAX;
            end else begin
               over    = (g > GROUP_LAST) || (g == GROUP_LAST && d > TOP_GROUP_MAX_DATA);
               v       = acc;
               acc     = '0;
               grp_idx = '0;
               case (phase)
                  PH_DELTA: begin
                     delta    = (v >> 1) ^ (32'd0 - {31'd0, v[0]});
                     prev_pix = prev_pix + delta[15:0];
                     run_left = run_left - 24'd1;
                     if (run_left == 0) begin
                        if (pix_left == 0) done = 1'b1;
                        else phase = PH_ZERO_RUN;
                     end
                     outs.push_back('{prev_pix, 24'd1, done, over, 1'b0});
                  end
                  PH_NZ_RUN: begin
                     err = over;
                     if (v > {8'd0, pix_left}) begin
                        v   = {8'd0, pix_left};
                        err = 1'b1;
                     end
                     pix_left = pix_left - v[23:0];
                     if (v != 0) begin
                        phase    = PH_DELTA;
                        run_left = v[23:0];
                        if (err) outs.push_back('{16'sd0, 24'd0, 1'b0, 1'b1, 1'b0});
                     end else if (pix_left == 0) begin
                        // frame closes with no run behind the count
                        done = 1'b1;
                        outs.push_back('{16'sd0, 24'd0, 1'b1, err, 1'b0});
                     end else begin
                        phase = PH_ZERO_RUN;
                        if (err) outs.push_back('{16'sd0, 24'd0, 1'b0, 1'b1, 1'b0});
                     end
                  end
                  default: begin
                     err = over;
                     if (v > {8'd0, pix_left}) begin
                        v   = {8'd0, pix_left};
                        err = 1'b1;
                     end
                     pix_left = pix_left - v[23:0];
                     phase    = PH_NZ_RUN;
                     if (v != 0 || err) outs.push_back('{16'sd0, v[23:0], 1'b0, err, 1'b0});
                  end
               endcase
               // rest of the word is padding once the frame is complete
               if (done) begin
                  rearm_decoder();
                  stop = 1'b1;
               end
            end
         end
      end
      if (outs.size() > 0) begin
         tail      = outs.pop_back();
         tail.last = 1'b1;
         outs.push_back(tail);
      end
      foreach (outs[k]) expected_runs.push_back(outs[k]);
   endfunction

   // ------------------------------------------------------------------
   // Encoder for well-formed frames
   // ------------------------------------------------------------------
   function automatic void queue_word(input logic [31:0] w);
      pending_words.push_back(w);
      words_queued++;
   endfunction

   function automatic logic [31:0] zig(input int s);
      return (s <<< 1) ^ (s >>> 31);
   endfunction

   // 3-bit groups, least significant first, top bit marks continuation.
   function automatic void put_value(input logic [31:0] v);
      logic [31:0] rest;
      rest = v;
      do begin
         code_nibs.push_back({(rest >> 3) != 0, rest[2:0]});
         rest = rest >> 3;
      end while (rest != 0);
   endfunction

   // Code of a chosen group length with random content and a fixed last group.
   function automatic void put_long(input int groups, input logic [2:0] last_d);
      for (int k = 0; k < groups - 1; k++)
         code_nibs.push_back({1'b1, 3'($urandom_range(7))});
      code_nibs.push_back({1'b0, last_d});
   endfunction

   function automatic void put_delta(input bit inject);
      int unsigned r;
      r = $urandom_range(9);
      if (r == 0) put_value($urandom);
      else if (r == 1 && inject) put_long($urandom_range(14, 11), 3'($urandom_range(7)));
      else put_value(zig(int'($urandom_range(80)) - 40));
   endfunction

   // Pack the nibble stream into words; padding after a frame end is random.
   function automatic void flush_code();
      logic [31:0] w;
      while (code_nibs.size() != 0) begin
         w = '0;
         for (int k = 0; k < NIBBLES; k++)
            w = {w[27:0], (code_nibs.size() != 0) ? code_nibs.pop_front()
                                                  : 4'($urandom_range(15))};
         queue_word(w);
      end
   endfunction

   function automatic int unsigned draw_zero_run(input int unsigned left);
      int unsigned r;
      r = $urandom_range(3);
      if (left == 0 || r == 0) return 0;
      if (r == 1) return left;
      return $urandom_range(left);
   endfunction

   // One frame of alternating runs; overruns are clamped so the encoder's
   // pixel budget stays in step with the decoder's.
   function automatic void build_frame(input int unsigned frame_len, input bit inject);
      int unsigned left;
      int unsigned z;
      int unsigned nz;
      left = frame_len;
      do begin
         z = draw_zero_run(left);
         if (inject && $urandom_range(3) == 0) begin
            put_value(left + 1 + $urandom_range(50));
            z = left;
         end else begin
            put_value(z);
         end
         left = left - z;
         if (left == 0 || $urandom_range(9) == 0) nz = 0;
         else nz = $urandom_range(left < 6 ? left : 6, 1);
         if (inject && $urandom_range(3) == 0) begin
            put_value(left + 1 + $urandom_range(50));
            nz = left;
         end else begin
            put_value(nz);
         end
         left = left - nz;
         repeat (nz) put_delta(inject);
      end while (left != 0);
      flush_code();
   endfunction

   // ------------------------------------------------------------------
   // Idle shaping: mostly short gaps, a few long ones
   // ------------------------------------------------------------------
   function automatic int unsigned draw_gap();
      int unsigned r;
      if (quiet) return 0;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // ------------------------------------------------------------------
   // Driver: feeds req_* from pending_words, predicts on each transaction
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            decode_word(req_tdata);
            words_accepted++;
         end
         if (req_tvalid && !req_tready) begin
            // hold the word until it is taken
         end else if (send_gap > 0) begin
            send_gap   <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_words.pop_front();
            send_gap   <= draw_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: checks each rsp transaction against the oldest prediction
   // ------------------------------------------------------------------
   function automatic void report_run(input string what, input run_type want,
                                      input run_type got);
      if (fail_count < 10)
         $display({"%s: expected pix=%0d cnt=%0d done=%0b err=%0b last=%0b,",
                   " got pix=%0d cnt=%0d done=%0b err=%0b last=%0b"},
                  what, want.pixel, want.count, want.done, want.err, want.last,
                  got.pixel, got.count, got.done, got.err, got.last);
      fail_count++;
   endfunction

   function automatic void check_run();
      run_type got;
      run_type want;
      got = '{rsp_tdata[15:0], rsp_tdata[39:16], rsp_tuser[0], rsp_tuser[1], rsp_tlast};
      if (expected_runs.size() == 0) begin
         report_run("unexpected run", '0, got);
      end else begin
         want = expected_runs.pop_front();
         if (got !== want) report_run("run mismatch", want, got);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_run();
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(3) == 0) begin
            stall_left <= draw_gap();
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequencing
   // ------------------------------------------------------------------
   // Idle means every queued word taken and every predicted run seen; the
   // settle time covers a word that produces no run.
   task automatic wait_idle();
      @(posedge clock);
      while (words_accepted != words_queued || expected_runs.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // A frame_pixels write also rearms the decoder.
   task automatic set_frame(input logic [23:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      frame_cfg = value;
      rearm_decoder();
   endtask

   logic [23:0] frame_sizes[10] = '{24'd1, 24'd6, 24'd16777215, 24'd2, 24'd23,
                                    24'd0, 24'd64, 24'd3, 24'd307200, 24'd11};

   initial begin
      int unsigned directed_words;
      int unsigned phase_start;
      int unsigned p;
      frame_cfg = FRAME_PIXELS_RESET;
      rearm_decoder();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset frame size: all-zero and all-one words; the long code left by
      // the all-ones word overruns the frame and the next count closes it.
      queue_word(32'h0000_0000);
      queue_word(32'hFFFF_FFFF);
      queue_word(32'h0000_0000);

      set_frame(24'd5);
      // zero run, then deltas up, down and to the top of the range
      put_value(2); put_value(3);
      put_value(zig(1)); put_value(zig(-3)); put_value(zig(32767));
      flush_code();
      // whole frame as one zero run, closed by an empty count
      put_value(5); put_value(0); flush_code();
      // zero run longer than the frame
      put_value(9); put_value(0); flush_code();
      // nonzero run longer than the frame, then edge codes: widest value,
      // overlong, too many bits in the top group, exactly full, wraparound
      put_value(0); put_value(9);
      put_value(32'hFFFF_FFFF);
      put_long(12, 3'd3);
      put_long(11, 3'd4);
      put_long(11, 3'd3);
      put_value(zig(-32768));
      flush_code();
      // empty nonzero run mid frame goes back to a zero-run count
      put_value(1); put_value(0); put_value(0); put_value(4);
      repeat (4) put_delta(1'b0);
      flush_code();

      set_frame(24'd0);
      // empty frame: two counts close it, any nonzero count is flagged
      put_value(0); put_value(0); flush_code();
      put_value(3); put_value(0); flush_code();
      put_value(0); put_value(2); flush_code();

      directed_words = words_queued;
      p = 0;
      while (words_queued - directed_words < RANDOM_WORDS) begin
         set_frame(frame_sizes[p % 10]);
         phase_start = words_queued;
         while (words_queued - phase_start < 28)
            build_frame(frame_sizes[p % 10], $urandom_range(7) == 0);
         // trailing noise leaves a frame half done for the next write to drop
         repeat ($urandom_range(2)) queue_word($urandom);
         p++;
      end

      wait_idle();
      if (fail_count == 0 && expected_runs.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("simulation failed");
      $finish;
   end

endmodule
